// ===== src/lsf_pkg.sv =====
// Shared types, constants and the per-channel sharpening function of the sharpening filter.
package lsf_pkg;

    // Field and register widths.
    localparam int CHAN_W        = 8;
    localparam int PIXEL_W       = 3 * CHAN_W;
    localparam int FRAME_W_BITS  = 12;
    localparam int FRAME_H_BITS  = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]    CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]    CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET    = 12'd640;
    localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET    = 16'd480;

    // Smallest frame dimension that the filter works with.
    localparam int MIN_DIM = 3;

    // Operation codes of an input beat.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Stencil constants.
    localparam int SHARP_GAIN = 5;
    localparam int CHAN_MAX   = 255;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_LVL_W = 3;
    localparam logic [QUEUE_LVL_W-1:0] QUEUE_LEVEL_MAX = 3'd4;

    typedef logic [PIXEL_W-1:0] t_pixel;

    // One classified item on its way to the back.
    typedef struct packed {
        logic   sharp;
        logic   done;
        t_pixel centre;
        t_pixel left;
        t_pixel right;
        t_pixel up;
        t_pixel down;
    } t_item;

    // Five times the centre minus the four cross neighbours, limited to 0..255.
    function automatic logic [CHAN_W-1:0] sharpen_chan(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] l,
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] u,
        input logic [CHAN_W-1:0] d
    );
        logic        [10:0] gain;
        logic        [9:0]  sum;
        logic signed [11:0] diff;
        logic [CHAN_W-1:0]  res;
        gain = 11'(c) * 11'(SHARP_GAIN);
        sum  = 10'(l) + 10'(r) + 10'(u) + 10'(d);
        diff = $signed({1'b0, gain}) - $signed({2'b00, sum});
        if (diff < 12'sd0) begin
            res = '0;
        end else if (diff > 12'(CHAN_MAX)) begin
            res = CHAN_W'(CHAN_MAX);
        end else begin
            res = diff[CHAN_W-1:0];
        end
        return res;
    endfunction

    // Applies the stencil to all three channels of a pixel.
    function automatic t_pixel sharpen_pixel(
        input t_pixel c,
        input t_pixel l,
        input t_pixel r,
        input t_pixel u,
        input t_pixel d
    );
        t_pixel res;
        res[23:16] = sharpen_chan(c[23:16], l[23:16], r[23:16], u[23:16], d[23:16]);
        res[15:8]  = sharpen_chan(c[15:8],  l[15:8],  r[15:8],  u[15:8],  d[15:8]);
        res[7:0]   = sharpen_chan(c[7:0],   l[7:0],   r[7:0],   u[7:0],   d[7:0]);
        return res;
    endfunction

endpackage

// ===== src/laplacian_sharpen_filter.sv =====
// Top level of the streaming 3x3 cross sharpening filter for RGB pixels.
// The filter takes one beat per clock while full is low and gives results one image row
// behind the input: the pixel of row r-1 at column c leaves when the pixel of row r at
// column c is taken, and flush beats then give the last row, with frame_done on its final
// pixel. The first row gives no results, and a pixel beat during a pending flush is
// dropped. A result reaches the outputs through the line store read stage, the queue and
// the output register. Sustained rate is one beat per cycle while full is low, set by the
// row r-1 line store, which is written and read at two addresses in the same cycle; full
// rises only while the four-entry result queue and the read stage hold four results.
// Line stores are not cleared after reset, so there is no start-up pass.
module laplacian_sharpen_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_operation,
    input  logic [lsf_pkg::CHAN_W-1:0]     i_red_in,
    input  logic [lsf_pkg::CHAN_W-1:0]     i_green_in,
    input  logic [lsf_pkg::CHAN_W-1:0]     i_blue_in,
    output logic                           empty,
    input  logic                           pop,
    output logic [lsf_pkg::CHAN_W-1:0]     o_red_out,
    output logic [lsf_pkg::CHAN_W-1:0]     o_green_out,
    output logic [lsf_pkg::CHAN_W-1:0]     o_blue_out,
    output logic                           o_frame_done
);

    logic                            w_fifo_push;
    logic                            w_fifo_pop;
    logic                            w_fifo_empty;
    logic [lsf_pkg::QUEUE_LVL_W-1:0] w_level;
    lsf_pkg::t_item                  w_item_in;
    lsf_pkg::t_item                  w_item_out;

    // Front: classification and line stores.
    lsf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_queue_level (w_level),
        .o_item_push   (w_fifo_push),
        .o_item        (w_item_in)
    );

    // Queue between front and back.
    lsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fifo_push),
        .i_item  (w_item_in),
        .i_pop   (w_fifo_pop),
        .o_item  (w_item_out),
        .o_empty (w_fifo_empty),
        .o_level (w_level)
    );

    // Back: stencil arithmetic and result register.
    lsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item_out),
        .i_item_empty (w_fifo_empty),
        .o_item_pop   (w_fifo_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_done (o_frame_done)
    );

`ifndef SYNTH
    // The room check in the front must keep the queue from overflowing.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_push && !w_fifo_pop) |-> (w_level < lsf_pkg::QUEUE_LEVEL_MAX))
        else $error("result queue overflow");

    // While the queue holds a result, the output register must hold a valid beat in the next cycle.
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fifo_empty |=> !empty)
        else $error("queued result not presented");

    // The back only takes from the queue when an entry is there.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_pop |-> !w_fifo_empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== src/lsf_front.sv =====
// Front of the sharpening filter: configuration, raster counters, classification and line stores.
module lsf_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_operation,
    input  logic [lsf_pkg::CHAN_W-1:0]          i_red_in,
    input  logic [lsf_pkg::CHAN_W-1:0]          i_green_in,
    input  logic [lsf_pkg::CHAN_W-1:0]          i_blue_in,
    input  logic [lsf_pkg::QUEUE_LVL_W-1:0]     i_queue_level,
    output logic                                o_item_push,
    output lsf_pkg::t_item                      o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > lsf_pkg::FRAME_W_BITS) ? CW + 1 : lsf_pkg::FRAME_W_BITS;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MIN_W_E = EW'(lsf_pkg::MIN_DIM);
    localparam int HW = lsf_pkg::FRAME_H_BITS;

    // Configuration and raster state.
    logic [lsf_pkg::FRAME_W_BITS-1:0] r_frame_width;
    logic [HW-1:0]                    r_frame_height;
    logic [CW-1:0]                    r_col, n_col;
    logic [HW-1:0]                    r_row, n_row;
    logic                             r_flush_pending, n_flush_pending;
    logic [CW-1:0]                    r_flush_col, n_flush_col;

    // Stage after the line store read.
    logic                             r_s1_valid;
    logic                             r_s1_pix;
    logic                             r_s1_sharp;
    logic                             r_s1_done;
    logic [CW-1:0]                    r_s1_col;
    lsf_pkg::t_pixel                  r_s1_down;
    lsf_pkg::t_pixel                  r_left;
    lsf_pkg::t_pixel                  r_rd_centre;
    lsf_pkg::t_pixel                  r_rd_right;
    lsf_pkg::t_pixel                  r_rd_up;

    // Line stores for rows r-1 and r-2.
    lsf_pkg::t_pixel                  r_prev_line  [MAX_WIDTH];
    lsf_pkg::t_pixel                  r_older_line [MAX_WIDTH];

    logic                             w_acc;
    logic [EW-1:0]                    w_fw_ext;
    logic [EW-1:0]                    w_w_eff;
    logic [EW-1:0]                    w_w_last_e;
    logic [CW-1:0]                    w_last;
    logic [HW-1:0]                    w_h_last;
    logic [CW-1:0]                    w_c;
    logic [HW-1:0]                    w_r;
    logic [CW-1:0]                    w_fc;
    logic [CW-1:0]                    w_c_right;
    logic [CW-1:0]                    w_rd_addr;
    logic [lsf_pkg::QUEUE_LVL_W-1:0]  w_in_flight;
    lsf_pkg::t_pixel                  w_px;
    logic                             w_pix_go;
    logic                             w_flush_go;
    logic                             w_has_out;
    logic                             w_sharp;
    logic                             w_done;

    // Room check: queued items plus the one in the read stage.
    assign w_in_flight = i_queue_level + lsf_pkg::QUEUE_LVL_W'(r_s1_valid);
    assign o_full      = (w_in_flight >= lsf_pkg::QUEUE_LEVEL_MAX);
    assign w_acc       = i_push && !o_full;
    assign w_px        = {i_red_in, i_green_in, i_blue_in};

    // Effective frame size, limited to the supported range.
    always_comb begin
        w_fw_ext = EW'(r_frame_width);
        if (w_fw_ext < MIN_W_E) begin
            w_w_eff = MIN_W_E;
        end else if (w_fw_ext > MAX_W_E) begin
            w_w_eff = MAX_W_E;
        end else begin
            w_w_eff = w_fw_ext;
        end
        w_w_last_e = w_w_eff - 1'b1;
        w_last     = w_w_last_e[CW-1:0];
        w_h_last   = (r_frame_height < HW'(lsf_pkg::MIN_DIM)) ? HW'(lsf_pkg::MIN_DIM - 1)
                                                               : r_frame_height - 1'b1;
    end

    // Counters saturate at the last column or row when the size shrinks.
    assign w_c       = (r_col < w_last) ? r_col : w_last;
    assign w_r       = (r_row < w_h_last) ? r_row : w_h_last;
    assign w_fc      = (r_flush_col < w_last) ? r_flush_col : w_last;
    assign w_c_right = (w_c == w_last) ? '0 : w_c + 1'b1;
    assign w_rd_addr = w_flush_go ? w_fc : w_c;

    // Classification of the accepted beat and next raster position.
    always_comb begin
        n_col           = r_col;
        n_row           = r_row;
        n_flush_pending = r_flush_pending;
        n_flush_col     = r_flush_col;
        w_pix_go        = 1'b0;
        w_flush_go      = 1'b0;
        w_has_out       = 1'b0;
        w_sharp         = 1'b0;
        w_done          = 1'b0;
        if (w_acc) begin
            if (i_operation == lsf_pkg::OP_FLUSH) begin
                if (r_flush_pending) begin
                    w_flush_go = 1'b1;
                    w_has_out  = 1'b1;
                    if (w_fc == w_last) begin
                        w_done          = 1'b1;
                        n_flush_pending = 1'b0;
                        n_flush_col     = '0;
                    end else begin
                        n_flush_col = w_fc + 1'b1;
                    end
                end
            end else if (!r_flush_pending) begin
                w_pix_go  = 1'b1;
                w_has_out = (w_r != '0);
                w_sharp   = (w_r >= HW'(2)) && (w_c != '0) && (w_c < w_last);
                if (w_c == w_last) begin
                    n_col = '0;
                    if (w_r == w_h_last) begin
                        n_row           = '0;
                        n_flush_pending = 1'b1;
                        n_flush_col     = '0;
                    end else begin
                        n_row = w_r + 1'b1;
                    end
                end else begin
                    n_col = w_c + 1'b1;
                    n_row = w_r;
                end
            end
        end
    end

    // Control registers and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= lsf_pkg::FRAME_W_RESET;
            r_frame_height  <= lsf_pkg::FRAME_H_RESET;
            r_col           <= '0;
            r_row           <= '0;
            r_flush_pending <= 1'b0;
            r_flush_col     <= '0;
            r_s1_valid      <= 1'b0;
            r_s1_pix        <= 1'b0;
        end else begin
            r_col           <= n_col;
            r_row           <= n_row;
            r_flush_pending <= n_flush_pending;
            r_flush_col     <= n_flush_col;
            r_s1_valid      <= w_has_out;
            r_s1_pix        <= w_pix_go;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsf_pkg::CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[lsf_pkg::FRAME_W_BITS-1:0];
                    end
                    lsf_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[HW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload of the read stage; the left neighbor is the previous pixel's centre.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_sharp <= w_sharp;
            r_s1_done  <= w_done;
            r_s1_col   <= w_c;
            r_s1_down  <= w_px;
        end
        if (r_s1_pix) begin
            r_left <= r_rd_centre;
        end
    end

    // Row r-1 store: new pixel written, centre and right neighbor read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_pix_go) begin
            r_prev_line[w_c] <= w_px;
            r_rd_right       <= r_prev_line[w_c_right];
        end
        if (w_pix_go || w_flush_go) begin
            r_rd_centre <= r_prev_line[w_rd_addr];
        end
    end

    // Row r-2 store: takes the old centre in the cycle after it was read.
    always_ff @(posedge i_clk) begin
        if (r_s1_pix) begin
            r_older_line[r_s1_col] <= r_rd_centre;
        end
        if (w_pix_go) begin
            r_rd_up <= r_older_line[w_c];
        end
    end

    // Classified item toward the queue.
    assign o_item_push   = r_s1_valid;
    assign o_item.sharp  = r_s1_sharp;
    assign o_item.done   = r_s1_done;
    assign o_item.centre = r_rd_centre;
    assign o_item.left   = r_left;
    assign o_item.right  = r_rd_right;
    assign o_item.up     = r_rd_up;
    assign o_item.down   = r_s1_down;

endmodule

// ===== src/lsf_queue.sv =====
// Short item queue that decouples the front from the back of the sharpening filter.
module lsf_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  lsf_pkg::t_item                  i_item,
    input  logic                            i_pop,
    output lsf_pkg::t_item                  o_item,
    output logic                            o_empty,
    output logic [lsf_pkg::QUEUE_LVL_W-1:0] o_level
);

    lsf_pkg::t_item                   r_mem [lsf_pkg::QUEUE_DEPTH];
    logic [lsf_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [lsf_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [lsf_pkg::QUEUE_LVL_W-1:0]  r_level;
    logic                             w_pop;

    assign o_empty = (r_level == '0);
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && w_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/lsf_back.sv =====
// Back of the sharpening filter: stencil arithmetic and the result output register.
module lsf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lsf_pkg::t_item             i_item,
    input  logic                       i_item_empty,
    output logic                       o_item_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [lsf_pkg::CHAN_W-1:0] o_red_out,
    output logic [lsf_pkg::CHAN_W-1:0] o_green_out,
    output logic [lsf_pkg::CHAN_W-1:0] o_blue_out,
    output logic                       o_frame_done
);

    logic            r_out_valid;
    lsf_pkg::t_pixel r_out_px;
    logic            r_out_done;
    lsf_pkg::t_pixel w_px;
    logic            w_load;

    // Interior pixels are sharpened, border and flushed pixels pass through.
    assign w_px = i_item.sharp ? lsf_pkg::sharpen_pixel(i_item.centre, i_item.left,
                                                        i_item.right, i_item.up, i_item.down)
                               : i_item.centre;

    // The output register refills whenever it is empty or its beat is taken.
    assign w_load     = !i_item_empty && (!r_out_valid || i_pop);
    assign o_item_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_px   <= w_px;
            r_out_done <= i_item.done;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_red_out    = r_out_px[23:16];
    assign o_green_out  = r_out_px[15:8];
    assign o_blue_out   = r_out_px[7:0];
    assign o_frame_done = r_out_done;

endmodule
